@@ rtl/cbh_pkg.sv @@
// Shared types and constants for the contrast band histogram.
// No dependencies; imported by the bin calculator, the top level and the testbench.
package cbh_pkg;

  // Opcodes carried by the mode field of an input word.
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } cbh_mode_e;

  // Q4.12 log values: one unit is 2**Q_FRAC_BITS.
  localparam int unsigned Q_FRAC_BITS = 12;
  localparam int unsigned Q_ONE       = 1 << Q_FRAC_BITS;

  // Contrast magnitude below 0.05 in Q4.12.
  localparam int unsigned HALF_BIN_LIMIT = 204;

  // Field widths of the interface.
  localparam int unsigned LOG_W   = 17;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned BAND_W  = 2;
  localparam int unsigned LBIN_W  = 8;
  localparam int unsigned CBIN_W  = 4;
  localparam int unsigned BCNT_W  = 24;
  localparam int unsigned TOTAL_W = 32;

  // Out-of-range flags of one sample.
  typedef struct packed {
    logic lum_oor;
    logic con_oor;
  } cbh_flags_t;

endpackage

@@ rtl/cbh_mem.sv @@
// Single-port-write, single-port-read synchronous memory for the bin counters.
// Read data is registered. No dependencies.
module cbh_mem #(
  parameter int unsigned DEPTH  = 9660,
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cbh_bin_calc.sv @@
// Background and contrast bin calculation for one sample, with range flags.
// Depends on cbh_pkg.
module cbh_bin_calc
  import cbh_pkg::*;
#(
  parameter int unsigned LUM_BINS      = 161,
  parameter int unsigned CONTRAST_BINS = 15,
  parameter int unsigned LUM_IDX_W     = 8,
  parameter int unsigned CON_IDX_W     = 4
) (
  input  logic signed [LOG_W-1:0] pixel_i,
  input  logic signed [LOG_W-1:0] blurred_i,
  input  logic [THR_W-1:0]        threshold_i,
  output logic [LUM_IDX_W-1:0]    lum_idx_o,
  output logic [CON_IDX_W-1:0]    con_idx_o,
  output cbh_flags_t              flags_o
);

  localparam int unsigned LUM_OFFSET = (LUM_BINS - 1) / 2;
  localparam int unsigned CENTRE     = CONTRAST_BINS / 2;
  localparam int unsigned T_W        = 23;
  localparam int unsigned XI_W       = T_W - Q_FRAC_BITS;
  localparam int unsigned G_W        = LOG_W + 1;

  localparam logic signed [T_W-1:0] LUM_BIAS = T_W'(LUM_OFFSET * Q_ONE + Q_ONE / 2);
  localparam logic signed [T_W-1:0] CON_BIAS = T_W'(CENTRE * Q_ONE + Q_ONE / 2);
  localparam logic signed [T_W-1:0] TRUNC_FIX = T_W'(Q_ONE - 1);
  localparam logic signed [G_W-1:0] HALF_LIM = G_W'(HALF_BIN_LIMIT);

  logic signed [G_W-1:0]  g;
  logic signed [G_W-1:0]  thr;
  logic signed [T_W-1:0]  b_ext;
  logic signed [T_W-1:0]  g_ext;
  logic signed [T_W-1:0]  tl;
  logic signed [T_W-1:0]  tc;
  logic signed [T_W-1:0]  tl_adj;
  logic signed [T_W-1:0]  tc_adj;
  logic signed [XI_W-1:0] xi;
  logic signed [XI_W-1:0] gi;

  always_comb begin
    g      = G_W'(pixel_i) - G_W'(blurred_i);
    thr    = $signed(G_W'(threshold_i));
    b_ext  = T_W'(blurred_i);
    g_ext  = T_W'(g);
    tl     = (b_ext <<< 3) + (b_ext <<< 1) + LUM_BIAS;
    tc     = (g_ext <<< 3) + (g_ext <<< 1) + CON_BIAS;
    // truncate toward zero
    tl_adj = tl + (tl[T_W-1] ? TRUNC_FIX : '0);
    tc_adj = tc + (tc[T_W-1] ? TRUNC_FIX : '0);
    xi     = tl_adj[T_W-1:Q_FRAC_BITS];
    gi     = tc_adj[T_W-1:Q_FRAC_BITS];

    flags_o.lum_oor = (xi < 0) || (int'(xi) >= int'(LUM_BINS));
    flags_o.con_oor = (gi < 0) || (int'(gi) >= int'(CONTRAST_BINS));
    lum_idx_o       = LUM_IDX_W'(xi);

    if (g > thr && g <= HALF_LIM) begin
      con_idx_o = CON_IDX_W'(CENTRE + 1);
    end else if (g < -thr && g >= -HALF_LIM) begin
      con_idx_o = CON_IDX_W'(CENTRE - 1);
    end else begin
      con_idx_o = CON_IDX_W'(gi);
    end
  end

endmodule

@@ rtl/contrast_band_histogram.sv @@
// Top level of the per-band contrast histogram.
// Depends on cbh_pkg, cbh_bin_calc and cbh_mem.
//
// The counters live in one synchronous memory of LUM_BINS*CONTRAST_BINS*BANDS
// words. After reset the block sweeps the memory to zero, one word a cycle
// (9660 words at the default sizes), and holds in_stall_o high meanwhile;
// configuration writes are taken at any time. The block works on one word at
// a time, each pass going through the single memory read port: a sample is
// binned and its counter incremented, a bin read fetches one counter, and a
// band finish sums the non-centre bins of each row with a non-empty centre
// bin into the total and sets the bins beside the centre to 1 if flat.
// A result held in the output register does not block the next input.
module contrast_band_histogram
  import cbh_pkg::*;
#(
  parameter int unsigned LUM_BINS      = 161,
  parameter int unsigned CONTRAST_BINS = 15,
  parameter int unsigned BANDS         = 4,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [THR_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [BAND_W-1:0]       band_i,
  input  logic signed [LOG_W-1:0] pixel_log_lum_i,
  input  logic signed [LOG_W-1:0] blurred_log_lum_i,
  input  logic [LBIN_W-1:0]       lum_bin_i,
  input  logic [CBIN_W-1:0]       contrast_bin_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BCNT_W-1:0]       bin_count_o,
  output logic [TOTAL_W-1:0]      total_count_o,
  output logic                    lum_out_of_range_o,
  output logic                    contrast_out_of_range_o
);

  localparam int unsigned DEPTH     = LUM_BINS * CONTRAST_BINS * BANDS;
  localparam int unsigned PLANE     = LUM_BINS * CONTRAST_BINS;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned LUM_IDX_W = $clog2(LUM_BINS);
  localparam int unsigned CON_IDX_W = $clog2(CONTRAST_BINS);
  localparam int unsigned CENTRE    = CONTRAST_BINS / 2;

  localparam logic [ADDR_W-1:0]    CTR_OFS  = ADDR_W'(CENTRE * LUM_BINS);
  localparam logic [ADDR_W-1:0]    HI_OFS   = ADDR_W'((CENTRE + 1) * LUM_BINS);
  localparam logic [ADDR_W-1:0]    LO_OFS   = ADDR_W'((CENTRE - 1) * LUM_BINS);
  localparam logic [ADDR_W-1:0]    STEP1    = ADDR_W'(LUM_BINS);
  localparam logic [ADDR_W-1:0]    STEP2    = ADDR_W'(2 * LUM_BINS);
  localparam logic [ADDR_W-1:0]    LAST_ADR = ADDR_W'(DEPTH - 1);
  localparam logic [LUM_IDX_W-1:0] LAST_M   = LUM_IDX_W'(LUM_BINS - 1);
  localparam logic [CON_IDX_W-1:0] LAST_N   = CON_IDX_W'(CONTRAST_BINS - 1);
  localparam logic [CON_IDX_W-1:0] PRE_CTR  = CON_IDX_W'(CENTRE - 1);
  localparam logic [THR_W-1:0]     THR_RST  = THR_W'(18);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_UPDATE,
    ST_RDATA,
    ST_F_CTR,
    ST_F_CTR_W,
    ST_F_RD,
    ST_F_ACC,
    ST_F_WR_HI,
    ST_F_WR_LO,
    ST_F_NEXT,
    ST_RESP
  } state_e;

  state_e                  state_q, state_d;
  logic [THR_W-1:0]        thr_q, thr_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  cbh_mode_e               mode_q, mode_d;
  logic [BAND_W-1:0]       band_q, band_d;
  logic signed [LOG_W-1:0] pix_q, pix_d;
  logic signed [LOG_W-1:0] blur_q, blur_d;
  logic [LUM_IDX_W-1:0]    x_q, x_d;
  logic [CON_IDX_W-1:0]    y_q, y_d;
  logic                    band_ok_q, band_ok_d;
  logic                    ok_q, ok_d;
  cbh_flags_t              flags_q, flags_d;
  logic [BCNT_W-1:0]       bin_q, bin_d;
  logic [TOTAL_W-1:0]      tot_q, tot_d;
  logic [ADDR_W-1:0]       row_q, row_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [LUM_IDX_W-1:0]    m_q, m_d;
  logic [CON_IDX_W-1:0]    n_q, n_d;
  logic                    grad_q, grad_d;
  logic                    out_valid_q, out_valid_d;
  logic [BCNT_W-1:0]       out_bin_q, out_bin_d;
  logic [TOTAL_W-1:0]      out_tot_q, out_tot_d;
  cbh_flags_t              out_flags_q, out_flags_d;

  logic                    in_accept;
  logic                    in_band_ok;
  logic [LUM_IDX_W-1:0]    calc_x;
  logic [CON_IDX_W-1:0]    calc_y;
  cbh_flags_t              calc_flags;
  logic [ADDR_W-1:0]       cell_addr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [COUNT_BITS-1:0]   mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [COUNT_BITS-1:0]   mem_rdata;
  logic [COUNT_BITS-1:0]   sat_inc;
  logic                    tot_en;
  logic [TOTAL_W-1:0]      tot_add;
  logic [TOTAL_W:0]        tot_sum;

  cbh_bin_calc #(
    .LUM_BINS      (LUM_BINS),
    .CONTRAST_BINS (CONTRAST_BINS),
    .LUM_IDX_W     (LUM_IDX_W),
    .CON_IDX_W     (CON_IDX_W)
  ) u_bin_calc (
    .pixel_i     (pix_q),
    .blurred_i   (blur_q),
    .threshold_i (thr_q),
    .lum_idx_o   (calc_x),
    .con_idx_o   (calc_y),
    .flags_o     (calc_flags)
  );

  cbh_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (COUNT_BITS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_band_ok = int'(band_i) < int'(BANDS);

  assign cell_addr = ADDR_W'(x_q) + ADDR_W'(y_q) * STEP1
                   + ADDR_W'(band_q) * ADDR_W'(PLANE);
  assign sat_inc   = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
  assign tot_sum   = {1'b0, tot_q} + {1'b0, tot_add};

  always_comb begin
    state_d     = state_q;
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    band_d      = band_q;
    pix_d       = pix_q;
    blur_d      = blur_q;
    x_d         = x_q;
    y_d         = y_q;
    band_ok_d   = band_ok_q;
    ok_d        = ok_q;
    flags_d     = flags_q;
    bin_d       = bin_q;
    row_d       = row_q;
    addr_d      = addr_q;
    m_d         = m_q;
    n_d         = n_q;
    grad_d      = grad_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_bin_d   = out_bin_q;
    out_tot_d   = out_tot_q;
    out_flags_d = out_flags_q;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cell_addr;
    tot_en      = 1'b0;
    tot_add     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LAST_ADR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          mode_d    = cbh_mode_e'(mode_i);
          band_d    = band_i;
          pix_d     = pixel_log_lum_i;
          blur_d    = blurred_log_lum_i;
          x_d       = LUM_IDX_W'(lum_bin_i);
          y_d       = CON_IDX_W'(contrast_bin_i);
          band_ok_d = in_band_ok;
          ok_d      = in_band_ok && (int'(lum_bin_i) < int'(LUM_BINS))
                      && (int'(contrast_bin_i) < int'(CONTRAST_BINS));
          flags_d   = '0;
          bin_d     = '0;
          unique case (cbh_mode_e'(mode_i))
            MODE_SAMPLE: state_d = ST_CALC;
            MODE_READ:   state_d = ST_READ;
            MODE_FINISH: begin
              row_d   = ADDR_W'(band_i) * ADDR_W'(PLANE);
              m_d     = '0;
              state_d = in_band_ok ? ST_F_CTR : ST_RESP;
            end
            default:     state_d = ST_RESP;
          endcase
        end
      end
      ST_CALC: begin
        x_d     = calc_x;
        y_d     = calc_y;
        flags_d = calc_flags;
        ok_d    = band_ok_q && !calc_flags.lum_oor && !calc_flags.con_oor;
        state_d = ST_READ;
      end
      ST_READ: begin
        mem_re  = ok_q;
        state_d = (mode_q == MODE_SAMPLE) ? ST_UPDATE : ST_RDATA;
      end
      ST_UPDATE: begin
        mem_we    = ok_q;
        mem_wdata = sat_inc;
        state_d   = ST_RESP;
      end
      ST_RDATA: begin
        bin_d   = ok_q ? BCNT_W'(mem_rdata) : '0;
        state_d = ST_RESP;
      end
      ST_F_CTR: begin
        mem_re    = 1'b1;
        mem_raddr = row_q + CTR_OFS;
        state_d   = ST_F_CTR_W;
      end
      ST_F_CTR_W: begin
        if (mem_rdata == '0) begin
          state_d = ST_F_NEXT;
        end else begin
          n_d     = '0;
          addr_d  = row_q;
          grad_d  = 1'b0;
          state_d = ST_F_RD;
        end
      end
      ST_F_RD: begin
        mem_re    = 1'b1;
        mem_raddr = addr_q;
        state_d   = ST_F_ACC;
      end
      ST_F_ACC: begin
        tot_en  = 1'b1;
        tot_add = TOTAL_W'(mem_rdata);
        grad_d  = grad_q || (mem_rdata != '0);
        if (n_q == LAST_N) begin
          state_d = grad_d ? ST_F_NEXT : ST_F_WR_HI;
        end else if (n_q == PRE_CTR) begin
          n_d     = n_q + CON_IDX_W'(2);
          addr_d  = addr_q + STEP2;
          state_d = ST_F_RD;
        end else begin
          n_d     = n_q + CON_IDX_W'(1);
          addr_d  = addr_q + STEP1;
          state_d = ST_F_RD;
        end
      end
      ST_F_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = row_q + HI_OFS;
        mem_wdata = COUNT_BITS'(1);
        tot_en    = 1'b1;
        tot_add   = TOTAL_W'(1);
        state_d   = ST_F_WR_LO;
      end
      ST_F_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = row_q + LO_OFS;
        mem_wdata = COUNT_BITS'(1);
        tot_en    = 1'b1;
        tot_add   = TOTAL_W'(1);
        state_d   = ST_F_NEXT;
      end
      ST_F_NEXT: begin
        if (m_q == LAST_M) begin
          state_d = ST_RESP;
        end else begin
          m_d     = m_q + LUM_IDX_W'(1);
          row_d   = row_q + ADDR_W'(1);
          state_d = ST_F_CTR;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_bin_d   = bin_q;
          out_tot_d   = tot_q;
          out_flags_d = flags_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    tot_d = tot_q;
    if (tot_en) begin
      tot_d = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      thr_q       <= THR_RST;
      clr_q       <= '0;
      mode_q      <= MODE_NOP;
      band_q      <= '0;
      pix_q       <= '0;
      blur_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      band_ok_q   <= 1'b0;
      ok_q        <= 1'b0;
      flags_q     <= '0;
      bin_q       <= '0;
      tot_q       <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      m_q         <= '0;
      n_q         <= '0;
      grad_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_bin_q   <= '0;
      out_tot_q   <= '0;
      out_flags_q <= '0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      clr_q       <= clr_d;
      mode_q      <= mode_d;
      band_q      <= band_d;
      pix_q       <= pix_d;
      blur_q      <= blur_d;
      x_q         <= x_d;
      y_q         <= y_d;
      band_ok_q   <= band_ok_d;
      ok_q        <= ok_d;
      flags_q     <= flags_d;
      bin_q       <= bin_d;
      tot_q       <= tot_d;
      row_q       <= row_d;
      addr_q      <= addr_d;
      m_q         <= m_d;
      n_q         <= n_d;
      grad_q      <= grad_d;
      out_valid_q <= out_valid_d;
      out_bin_q   <= out_bin_d;
      out_tot_q   <= out_tot_d;
      out_flags_q <= out_flags_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign bin_count_o             = out_bin_q;
  assign total_count_o           = out_tot_q;
  assign lum_out_of_range_o      = out_flags_q.lum_oor;
  assign contrast_out_of_range_o = out_flags_q.con_oor;

endmodule

@@ dv/tb_contrast_band_histogram.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for contrast_band_histogram: a directed table, then
// random phases with sender idling, receiver stalls and a long output hold-off.
// Depends on cbh_pkg and the contrast_band_histogram RTL.
module tb_contrast_band_histogram;
  import cbh_pkg::*;

  localparam int unsigned LUM_BINS    = 161;
  localparam int unsigned CON_BINS    = 15;
  localparam int unsigned BANDS       = 4;
  localparam int unsigned STORE_DEPTH = LUM_BINS * CON_BINS * BANDS;
  localparam int          CENTRE      = CON_BINS / 2;
  localparam longint      LUM_OFS     = (LUM_BINS - 1) / 2;
  localparam longint      QL          = longint'(Q_ONE);
  localparam longint      NEAR_LIM    = longint'(HALF_BIN_LIMIT);
  localparam int          LONG_HOLD   = 400;
  localparam int          CYCLE_LIMIT = 2_000_000;

  typedef struct {
    cbh_mode_e               mode;
    logic [BAND_W-1:0]       band;
    logic signed [LOG_W-1:0] pix;
    logic signed [LOG_W-1:0] blur;
    logic [LBIN_W-1:0]       lbin;
    logic [CBIN_W-1:0]       cbin;
  } word_t;

  typedef struct {
    logic [BCNT_W-1:0]  count;
    logic [TOTAL_W-1:0] total;
    cbh_flags_t         flags;
  } result_t;

  typedef struct {
    word_t   w;
    bit      known;
    result_t res;
  } dir_row_t;

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    cfg_we_i          = 1'b0;
  logic [THR_W-1:0]        cfg_wdata_i       = '0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              mode_i            = '0;
  logic [BAND_W-1:0]       band_i            = '0;
  logic signed [LOG_W-1:0] pixel_log_lum_i   = '0;
  logic signed [LOG_W-1:0] blurred_log_lum_i = '0;
  logic [LBIN_W-1:0]       lum_bin_i         = '0;
  logic [CBIN_W-1:0]       contrast_bin_i    = '0;
  logic                    out_valid_o;
  logic                    out_stall_i       = 1'b0;
  logic [BCNT_W-1:0]       bin_count_o;
  logic [TOTAL_W-1:0]      total_count_o;
  logic                    lum_out_of_range_o;
  logic                    contrast_out_of_range_o;

  logic [BCNT_W-1:0]  bin_store [STORE_DEPTH];
  logic [TOTAL_W-1:0] total_acc;
  logic [THR_W-1:0]   thr_cur;
  int unsigned        recent_cells[$];
  int                 hot_rows[4];
  result_t            pending_results[$];
  dir_row_t           dir_rows[$];
  int                 fail_cnt   = 0;
  int                 cycle_cnt  = 0;
  int unsigned        idle_pct   = 0;
  int unsigned        stall_pct  = 0;
  bit                 hold_req   = 1'b0;
  bit                 hold_on    = 1'b0;

  contrast_band_histogram u_top (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .mode_i                  (mode_i),
    .band_i                  (band_i),
    .pixel_log_lum_i         (pixel_log_lum_i),
    .blurred_log_lum_i       (blurred_log_lum_i),
    .lum_bin_i               (lum_bin_i),
    .contrast_bin_i          (contrast_bin_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .bin_count_o             (bin_count_o),
    .total_count_o           (total_count_o),
    .lum_out_of_range_o      (lum_out_of_range_o),
    .contrast_out_of_range_o (contrast_out_of_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned cell_at(int unsigned x, int unsigned y, int unsigned z);
    return x + y * LUM_BINS + z * LUM_BINS * CON_BINS;
  endfunction

  function automatic void bump(int unsigned idx);
    if (bin_store[idx] != '1) bin_store[idx] = bin_store[idx] + 1'b1;
  endfunction

  function automatic void finish_band(int unsigned z);
    longint sum;
    bit     flat;
    for (int unsigned m = 0; m < LUM_BINS; m++) begin
      if (bin_store[cell_at(m, CENTRE, z)] == '0) continue;
      flat = 1'b1;
      for (int unsigned n = 0; n < CON_BINS; n++)
        if (n != CENTRE && bin_store[cell_at(m, n, z)] != '0) flat = 1'b0;
      if (flat) begin
        bump(cell_at(m, CENTRE + 1, z));
        bump(cell_at(m, CENTRE - 1, z));
      end
      sum = longint'(total_acc);
      for (int unsigned n = 0; n < CON_BINS; n++)
        if (n != CENTRE) sum += longint'(bin_store[cell_at(m, n, z)]);
      total_acc = (sum > 64'h0000_0000_FFFF_FFFF) ? '1 : TOTAL_W'(sum);
    end
  endfunction

  function automatic result_t histogram_step(word_t w);
    result_t     r;
    longint      g, xi, gi, thr;
    int unsigned y, idx;
    r.count = '0;
    r.flags = '0;
    case (w.mode)
      MODE_SAMPLE: begin
        g   = longint'(w.pix) - longint'(w.blur);
        thr = longint'(thr_cur);
        xi  = (10 * longint'(w.blur) + LUM_OFS * QL + QL / 2) / QL;
        gi  = (10 * g + CENTRE * QL + QL / 2) / QL;
        r.flags.lum_oor = (xi < 0) || (xi >= longint'(LUM_BINS));
        r.flags.con_oor = (gi < 0) || (gi >= longint'(CON_BINS));
        if (!r.flags.lum_oor && !r.flags.con_oor) begin
          if (g > thr && g <= NEAR_LIM) y = CENTRE + 1;
          else if (g < -thr && g >= -NEAR_LIM) y = CENTRE - 1;
          else y = 32'(gi);
          idx = cell_at(32'(xi), y, 32'(w.band));
          bump(idx);
          recent_cells = {recent_cells, idx};
          if (recent_cells.size() > 32) void'(recent_cells.pop_front());
        end
      end
      MODE_FINISH: finish_band(32'(w.band));
      MODE_READ: begin
        if (w.lbin < LUM_BINS && w.cbin < CON_BINS)
          r.count = bin_store[cell_at(32'(w.lbin), 32'(w.cbin), 32'(w.band))];
      end
      default: ;
    endcase
    r.total = total_acc;
    return r;
  endfunction

  function automatic word_t rand_word();
    word_t       w;
    int unsigned k, idx;
    int          row, g, thr;
    w.band = BAND_W'($urandom_range(0, 3));
    w.pix  = LOG_W'($urandom);
    w.blur = LOG_W'($urandom);
    w.lbin = LBIN_W'($urandom);
    w.cbin = CBIN_W'($urandom);
    k = $urandom_range(0, 99);
    if (k < 80) w.mode = MODE_SAMPLE;
    else if (k < 92) w.mode = MODE_READ;
    else if (k < 95) w.mode = MODE_FINISH;
    else w.mode = MODE_NOP;
    if (w.mode == MODE_SAMPLE && $urandom_range(0, 99) >= 15) begin
      // keep most samples inside the table, clustered on a few rows
      if ($urandom_range(0, 1) != 0) row = hot_rows[$urandom_range(0, 3)];
      else row = $urandom_range(0, LUM_BINS - 1);
      thr = int'(thr_cur);
      k = $urandom_range(0, 99);
      if (k < 35) g = int'($urandom_range(0, 2 * thr)) - thr;
      else if (k < 65) g = int'($urandom_range(0, 600)) - 300;
      else g = int'($urandom_range(0, 7200)) - 3600;
      w.blur = LOG_W'((row - 80) * 410 + int'($urandom_range(0, 200)) - 100);
      w.pix  = LOG_W'(w.blur + g);
    end else if (w.mode == MODE_READ && recent_cells.size() != 0
                 && $urandom_range(0, 99) < 60) begin
      idx    = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
      w.lbin = LBIN_W'(idx % LUM_BINS);
      w.cbin = CBIN_W'((idx / LUM_BINS) % CON_BINS);
      w.band = BAND_W'(idx / (LUM_BINS * CON_BINS));
    end
    return w;
  endfunction

  function automatic void add_row(cbh_mode_e m, int bnd, int pix, int blur, int lb, int cb,
                                  bit known = 1'b0, int cnt = 0, int tot = 0,
                                  bit loor = 1'b0, bit coor = 1'b0);
    dir_row_t r;
    r.w.mode  = m;
    r.w.band  = BAND_W'(bnd);
    r.w.pix   = LOG_W'(pix);
    r.w.blur  = LOG_W'(blur);
    r.w.lbin  = LBIN_W'(lb);
    r.w.cbin  = CBIN_W'(cb);
    r.known   = known;
    r.res.count = BCNT_W'(cnt);
    r.res.total = TOTAL_W'(tot);
    r.res.flags.lum_oor = loor;
    r.res.flags.con_oor = coor;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void check_field(string label, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(word_t w, bit known, result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    mode_i            <= w.mode;
    band_i            <= w.band;
    pixel_log_lum_i   <= w.pix;
    blurred_log_lum_i <= w.blur;
    lum_bin_i         <= w.lbin;
    contrast_bin_i    <= w.cbin;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    r = histogram_step(w);
    if (known) r = typed_res;
    pending_results = {pending_results, r};
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    thr_cur      = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) out_stall_i <= hold_on || ($urandom_range(0, 99) < stall_pct);

  initial forever begin
    wait (hold_req);
    hold_on = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_on  = 1'b0;
    hold_req = 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    result_t e;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count %0d total %0d",
                 $time, bin_count_o, total_count_o);
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        check_field("bin_count", 32'(e.count), 32'(bin_count_o));
        check_field("total_count", e.total, total_count_o);
        check_field("lum_out_of_range", 32'(e.flags.lum_oor), 32'(lum_out_of_range_o));
        check_field("contrast_out_of_range", 32'(e.flags.con_oor),
                    32'(contrast_out_of_range_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("contrast_band_histogram test failed");
      $finish;
    end
  end

  initial begin
    result_t no_res;
    no_res = '{default: '0};
    for (int i = 0; i < STORE_DEPTH; i++) bin_store[i] = '0;
    total_acc = '0;
    thr_cur   = 8'd18;
    for (int i = 0; i < 4; i++) hot_rows[i] = $urandom_range(0, LUM_BINS - 1);

    add_row(MODE_READ,   0, 0, 0, 0, 0, 1'b1);
    add_row(MODE_READ,   3, 0, 0, 255, 15, 1'b1);
    add_row(MODE_NOP,    2, 0, 0, 0, 0, 1'b1);
    add_row(MODE_SAMPLE, 0, -65536, -65536, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
    add_row(MODE_SAMPLE, 1, 65535, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b1);
    add_row(MODE_SAMPLE, 1, 65535, -65536, 0, 0, 1'b1, 0, 0, 1'b1, 1'b1);
    add_row(MODE_SAMPLE, 0, 0, 0, 0, 0);
    add_row(MODE_SAMPLE, 0, 18, 0, 0, 0);
    add_row(MODE_SAMPLE, 0, 19, 0, 0, 0);
    add_row(MODE_SAMPLE, 0, 204, 0, 0, 0);
    add_row(MODE_SAMPLE, 0, -19, 0, 0, 0);
    add_row(MODE_SAMPLE, 0, -204, 0, 0, 0);
    add_row(MODE_SAMPLE, 0, -205, 0, 0, 0);
    add_row(MODE_SAMPLE, 1, -33382, -33382, 0, 0);
    add_row(MODE_SAMPLE, 1, -33383, -33383, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
    add_row(MODE_SAMPLE, 1, 32972, 32972, 0, 0);
    add_row(MODE_SAMPLE, 1, 32973, 32973, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0);
    add_row(MODE_SAMPLE, 2, 3071, 0, 0, 0);
    add_row(MODE_SAMPLE, 2, 3072, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b1);
    add_row(MODE_SAMPLE, 2, -3481, 0, 0, 0);
    add_row(MODE_SAMPLE, 2, -3482, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b1);
    add_row(MODE_SAMPLE, 3, 0, 0, 0, 0);
    add_row(MODE_FINISH, 3, 0, 0, 0, 0);
    add_row(MODE_READ,   3, 0, 0, 80, 8);
    add_row(MODE_FINISH, 0, 0, 0, 0, 0);
    add_row(MODE_READ,   0, 0, 0, 80, 7);
    add_row(MODE_FINISH, 1, 0, 0, 0, 0);
    add_row(MODE_READ,   1, 0, 0, 0, 8);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].w, dir_rows[i].known, dir_rows[i].res);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin write_threshold(8'd0);   idle_pct = 0;  stall_pct = 0;  end
        1: begin write_threshold(8'd204); idle_pct = 75; stall_pct = 0;  end
        2: begin
          write_threshold(THR_W'($urandom_range(1, 203)));
          idle_pct  = 0;
          stall_pct = 75;
        end
        default: begin write_threshold(8'd18); idle_pct = 19; stall_pct = 19; end
      endcase
      for (int j = 0; j < ((p == 3) ? 230 : 240); j++) begin
        // hold the output off while the sender keeps pushing
        if (p == 0 && j == 60) hold_req = 1'b1;
        offer(rand_word(), 1'b0, no_res);
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("contrast_band_histogram test passed");
    end else begin
      $display("contrast_band_histogram test failed");
    end
    $finish;
  end

endmodule
